// ----- rtl/core/s2b_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package s2b_pkg;

    // How many points of the current spline the window holds (saturates at full)
    typedef enum logic [1:0] {
        SEEN_NONE,
        SEEN_ONE,
        SEEN_TWO,
        SEEN_FULL
    } t_seen;

    // Per-segment control carried from the stage register to the result register
    typedef struct packed {
        logic first;     // segment opens the spline
        logic last;      // segment closes the spline
        logic run_last;  // final segment caused by its control point
    } t_seg_ctl;

endpackage

`default_nettype wire

// ----- rtl/core/s2b_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Control point channel
interface s2b_point_if #(
    parameter int COORD_BITS = 20
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         last_point;

    modport source (output valid, point_x, point_y, last_point, input ready);
    modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

// Bezier segment channel
interface s2b_seg_if #(
    parameter int COORD_BITS = 20
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] ctrl1_x;
    logic signed [COORD_BITS-1:0] ctrl1_y;
    logic signed [COORD_BITS-1:0] ctrl2_x;
    logic signed [COORD_BITS-1:0] ctrl2_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic                         run_last;
    logic                         spline_end;

    modport source (output valid, start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
                    end_x, end_y, run_last, spline_end, input ready);
    modport sink   (input valid, start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
                    end_x, end_y, run_last, spline_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/spline_to_bezier_segments_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// A segment goes through the stage register, then the result register. Throughput: one
// control point per cycle while the stage drains; a point flagged last that closes two
// segments holds the segment stage while the result register takes them one per cycle.
// Reset (synchronous, active low) empties the stage and result registers, clears the
// point window and starts a new spline.
module spline_to_bezier_segments_core #(
    parameter int COORD_BITS = 20
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    s2b_point_if.sink        i_pt,
    s2b_seg_if.source        o_seg
);
    import s2b_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int SW = CW + 4;     // weighted sums up to 12x a coordinate
    localparam int TW = CW + 2;     // operand of the divide-by-three
    localparam int S3 = TW + 1;     // reciprocal shift
    localparam logic [TW-1:0] RECIP3 = TW'(((64'd1 << S3) + 64'd2) / 64'd3);
    localparam logic [TW-1:0] OFS3   = TW'(64'd3 << (CW - 1));

    // Floored divide by three: bias to non-negative, reciprocal multiply, remove bias
    function automatic logic [CW-1:0] fl3(input logic signed [TW-1:0] v);
        logic [TW-1:0]   u;
        logic [2*TW-1:0] prod;
        logic [CW-1:0]   q;
        u    = $unsigned(v) + OFS3;
        prod = (2*TW)'(u) * (2*TW)'(RECIP3);
        q    = prod[S3+CW-1:S3];
        return {~q[CW-1], q[CW-2:0]};
    endfunction

    // One axis of a segment: {point0, point1, point2, point3}
    function automatic logic [4*CW-1:0] seg_axis(
        input logic signed [CW-1:0] q0,
        input logic signed [CW-1:0] q1,
        input logic signed [CW-1:0] q2,
        input logic signed [CW-1:0] q3,
        input logic                 first,
        input logic                 last
    );
        logic signed [SW-1:0] e0, e1, e2, e3;
        logic signed [SW-1:0] s0, s1, s2, s3;
        logic [CW-1:0]        b0, b1, b2, b3;
        e0 = SW'(q0);
        e1 = SW'(q1);
        e2 = SW'(q2);
        e3 = SW'(q3);
        s0 = e0 + (e1 <<< 1) + e2;
        s1 = first ? (e1 <<< 1) + e2
                   : (e0 + (e1 <<< 2) + (e1 <<< 1) + (e2 <<< 2) + e2) >>> 2;
        s2 = last  ? e1 + (e2 <<< 1)
                   : ((e1 <<< 2) + e1 + (e2 <<< 2) + (e2 <<< 1) + e3) >>> 2;
        s3 = e1 + (e2 <<< 1) + e3;
        b0 = first ? q1 : s0[CW+1:2];
        b1 = fl3(s1[TW-1:0]);
        b2 = fl3(s2[TW-1:0]);
        b3 = last ? q2 : s3[CW+1:2];
        return {b0, b1, b2, b3};
    endfunction

    // Point window, oldest first, and spline fill count
    logic signed [CW-1:0] r_w0_x, r_w0_y, r_w1_x, r_w1_y, r_w2_x, r_w2_y;
    t_seen                r_seen, n_seen;

    // Stage register: a snapshot of four points and the segments still owed
    logic                 r_v;
    logic                 r_do_a;   // segment ending at the window's newest point
    logic                 r_do_b;   // closing segment ending at the flagged point
    logic                 r_first_a, r_first_b;
    logic signed [CW-1:0] r_p0_x, r_p0_y, r_p1_x, r_p1_y, r_p2_x, r_p2_y, r_p3_x, r_p3_y;

    // Result register
    logic                 r_o_valid;
    logic signed [CW-1:0] r_b0_x, r_b0_y, r_b1_x, r_b1_y, r_b2_x, r_b2_y, r_b3_x, r_b3_y;
    t_seg_ctl             r_o_ctl;

    logic                 accept, ld_a, ld_b, load;
    logic                 out_free, emit, stage_last, sel_b;
    t_seg_ctl             seg_ctl;
    logic signed [CW-1:0] q0_x, q0_y, q1_x, q1_y, q2_x, q2_y;
    logic [4*CW-1:0]      ax_x, ax_y;

    // Handshake and stage control
    assign accept     = i_pt.valid && i_pt.ready;
    assign ld_a       = (r_seen == SEEN_TWO) || (r_seen == SEEN_FULL);
    assign ld_b       = i_pt.last_point && (r_seen != SEEN_NONE);
    assign load       = accept && (ld_a || ld_b);
    assign out_free   = !r_o_valid || o_seg.ready;
    assign emit       = r_v && out_free;
    assign stage_last = !(r_do_a && r_do_b);
    assign i_pt.ready = !r_v || (emit && stage_last);

    // Fill count follows each accepted point
    always_comb begin
        n_seen = r_seen;
        if (i_pt.last_point) begin
            n_seen = SEEN_NONE;
        end else begin
            unique case (r_seen)
                SEEN_NONE: n_seen = SEEN_ONE;
                SEEN_ONE:  n_seen = SEEN_TWO;
                SEEN_TWO:  n_seen = SEEN_FULL;
                SEEN_FULL: n_seen = SEEN_FULL;
                default:   n_seen = SEEN_NONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= SEEN_NONE;
            r_w0_x <= '0;
            r_w0_y <= '0;
            r_w1_x <= '0;
            r_w1_y <= '0;
            r_w2_x <= '0;
            r_w2_y <= '0;
        end else if (accept) begin
            r_seen <= n_seen;
            r_w0_x <= r_w1_x;
            r_w0_y <= r_w1_y;
            r_w1_x <= r_w2_x;
            r_w1_y <= r_w2_y;
            r_w2_x <= i_pt.point_x;
            r_w2_y <= i_pt.point_y;
        end
    end

    // Stage control: loading wins, since ready implies the stage drains this cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= 1'b0;
            r_do_a <= 1'b0;
            r_do_b <= 1'b0;
        end else if (load) begin
            r_v    <= 1'b1;
            r_do_a <= ld_a;
            r_do_b <= ld_b;
        end else if (emit && stage_last) begin
            r_v    <= 1'b0;
            r_do_a <= 1'b0;
            r_do_b <= 1'b0;
        end else if (emit) begin
            r_do_a <= 1'b0;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_first_a <= (r_seen == SEEN_TWO);
            r_first_b <= (r_seen == SEEN_ONE);
            r_p0_x    <= r_w0_x;
            r_p0_y    <= r_w0_y;
            r_p1_x    <= r_w1_x;
            r_p1_y    <= r_w1_y;
            r_p2_x    <= r_w2_x;
            r_p2_y    <= r_w2_y;
            r_p3_x    <= i_pt.point_x;
            r_p3_y    <= i_pt.point_y;
        end
    end

    // Segment select: the closing segment drops the oldest point
    assign sel_b            = !r_do_a;
    assign q0_x             = sel_b ? r_p1_x : r_p0_x;
    assign q0_y             = sel_b ? r_p1_y : r_p0_y;
    assign q1_x             = sel_b ? r_p2_x : r_p1_x;
    assign q1_y             = sel_b ? r_p2_y : r_p1_y;
    assign q2_x             = sel_b ? r_p3_x : r_p2_x;
    assign q2_y             = sel_b ? r_p3_y : r_p2_y;
    assign seg_ctl.first    = sel_b ? r_first_b : r_first_a;
    assign seg_ctl.last     = sel_b;
    assign seg_ctl.run_last = sel_b || !r_do_b;

    assign ax_x = seg_axis(q0_x, q1_x, q2_x, r_p3_x, seg_ctl.first, seg_ctl.last);
    assign ax_y = seg_axis(q0_y, q1_y, q2_y, r_p3_y, seg_ctl.first, seg_ctl.last);

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (emit) begin
            r_o_valid <= 1'b1;
        end else if (o_seg.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_b0_x  <= ax_x[4*CW-1:3*CW];
            r_b1_x  <= ax_x[3*CW-1:2*CW];
            r_b2_x  <= ax_x[2*CW-1:CW];
            r_b3_x  <= ax_x[CW-1:0];
            r_b0_y  <= ax_y[4*CW-1:3*CW];
            r_b1_y  <= ax_y[3*CW-1:2*CW];
            r_b2_y  <= ax_y[2*CW-1:CW];
            r_b3_y  <= ax_y[CW-1:0];
            r_o_ctl <= seg_ctl;
        end
    end

    assign o_seg.valid      = r_o_valid;
    assign o_seg.start_x    = r_b0_x;
    assign o_seg.start_y    = r_b0_y;
    assign o_seg.ctrl1_x    = r_b1_x;
    assign o_seg.ctrl1_y    = r_b1_y;
    assign o_seg.ctrl2_x    = r_b2_x;
    assign o_seg.ctrl2_y    = r_b2_y;
    assign o_seg.end_x      = r_b3_x;
    assign o_seg.end_y      = r_b3_y;
    assign o_seg.run_last   = r_o_ctl.run_last;
    assign o_seg.spline_end = r_o_ctl.last;

    // A loaded stage always owes at least one segment
    a_stage_owes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v |-> (r_do_a || r_do_b))
        else $error("stage holds an item with no segment owed");

    // The spline's closing segment is always the last one of its point
    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_seg.valid && o_seg.spline_end) |-> o_seg.run_last)
        else $error("closing segment not flagged as final of its point");

    // A point flagged last restarts the spline
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_pt.last_point) |=> (r_seen == SEEN_NONE))
        else $error("fill count not cleared after last point");

    // Input is held back only by a stage that cannot drain
    a_ready_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pt.ready |-> (r_v && !(emit && stage_last)))
        else $error("input stalled without a blocked stage");

endmodule

`default_nettype wire
